@@ rtl/srt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp package
// Shared widths, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package srt_pkg;

	localparam int unsigned NUM_MOTORS_DEF       = 2;
	localparam int unsigned TIMER_BASE_HZ_DEF    = 1000000;
	localparam int unsigned MIN_PERIOD_TICKS_DEF = 4;

	localparam int SPEED_W  = 18;
	localparam int STEP_W   = 17;
	localparam int PERIOD_W = 20;
	localparam int CFG_W    = 16;
	localparam int TICK_W   = 10;
	localparam int CIDX_W   = 2;
	localparam int CNT_W    = 19;

	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 20'hFFFFF;
	localparam logic [1:0] NO_MOTOR = 2'd2;

	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_STOP  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;
	localparam logic [1:0] MODE_PULSE = 2'd3;

	localparam logic [CIDX_W-1:0] CFG_START_SPEED = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_ACCEL_STEP  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_TICK_MS     = 2'd2;

	typedef struct packed {
		logic latch;
		logic cand_start;
		logic cnt_go;
		logic mul1;
		logic mul2;
		logic pick;
		logic per_go;
		logic per_cap;
		logic commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       start_refused;
		logic       tick_idle;
		logic       decel_path;
		logic       same;
		logic       div_done;
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/srt_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp divider
// Restoring divider, one quotient bit per cycle, pulses done when finished.
// ----------------------------------------------------------------------------
module srt_div #(
	parameter int DIV_W = 27,
	parameter int DVS_W = 18
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic      [DIV_W-1:0] quo,
	output logic                  done
);
	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fit;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign fit   = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			dvd_q <= {dvd_q[DIV_W-2:0], fit};
		end
	end

	assign quo  = dvd_q;
	assign done = done_q;
endmodule
`default_nettype wire

@@ rtl/srt_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp datapath
// Configuration, motor and ramp state, deceleration estimate, period divider
// and the result register.
// ----------------------------------------------------------------------------
module srt_dp #(
	parameter int NUM_MOTORS       = 2,
	parameter int TIMER_BASE_HZ    = 1000000,
	parameter int MIN_PERIOD_TICKS = 4,
	parameter int DIV_W            = 27
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [srt_pkg::CIDX_W-1:0]    cfg_index,
	input  wire logic [srt_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic [1:0]                    mode,
	input  wire logic                          motor,
	input  wire logic                          direction,
	input  wire logic [srt_pkg::SPEED_W-1:0]   target_speed,
	input  wire logic [srt_pkg::STEP_W-1:0]    step_count,
	input  wire srt_pkg::cmd_t                 cmd,
	output srt_pkg::sts_t                      sts,
	output logic                               accepted,
	output logic                               running,
	output logic [1:0]                         active_motor,
	output logic                               dir_out,
	output logic [srt_pkg::SPEED_W-1:0]        rate_pps,
	output logic [srt_pkg::PERIOD_W-1:0]       period_us,
	output logic [srt_pkg::STEP_W-1:0]         done_steps,
	output logic [srt_pkg::STEP_W-1:0]         goal_steps
);
	import srt_pkg::*;

	localparam int M1W = SPEED_W + CNT_W;
	localparam int M2W = M1W + TICK_W;
	localparam int RW  = STEP_W + 10;

	// Configuration
	logic [CFG_W-1:0]  start_q, acc_q;
	logic [TICK_W-1:0] tick_q;

	// Latched item
	logic [1:0]         mode_q;
	logic               motor_q, dir_q;
	logic [SPEED_W-1:0] tgt_q;
	logic [STEP_W-1:0]  steps_q;

	// Motor and ramp state
	logic               run_q   [NUM_MOTORS];
	logic               mdir_q  [NUM_MOTORS];
	logic [SPEED_W-1:0] spd_q   [NUM_MOTORS];
	logic [PERIOD_W-1:0] per_m_q [NUM_MOTORS];
	logic [STEP_W-1:0]  goal_q  [NUM_MOTORS];
	logic [STEP_W-1:0]  done_q  [NUM_MOTORS];
	logic [1:0]         active_q;
	logic               ramp_on_q;
	logic [SPEED_W-1:0] ramp_tgt_q, ramp_spd_q;

	// Work registers
	logic [SPEED_W-1:0]  cand_q;
	logic                same_q;
	logic [M1W-1:0]      mul1_q;
	logic [M2W-1:0]      prod_q;
	logic [RW-1:0]       rhs_q;
	logic [PERIOD_W-1:0] per_q;
	logic                per_ok_q;
	logic                acc_out_q;

	logic               m_ok, act_ok, act_run, counted, decel_path, decel;
	logic               a;
	logic [STEP_W-1:0]  goal_a, done_a, rem_m1, done_inc;
	logic [CFG_W-1:0]   acc_eff;
	logic [CNT_W-1:0]   cnt_num;
	logic [CNT_W-1:0]   sum_avg;
	logic [SPEED_W-1:0] cur, diff, dec_next, up_next, next_spd, start_min;
	logic [SPEED_W:0]   up_sum;
	logic [DIV_W-1:0]   dvd, quo;
	logic [SPEED_W-1:0] dvs;
	logic               div_done;
	logic [31:0]        q32;
	logic               refuse;

	assign a       = active_q[0];
	assign m_ok    = (32'(motor_q) < 32'(NUM_MOTORS));
	assign act_ok  = (32'(active_q) < 32'(NUM_MOTORS));
	assign act_run = act_ok && run_q[a];
	assign goal_a  = goal_q[a];
	assign done_a  = done_q[a];
	assign counted = (goal_a != '0) && (done_a < goal_a);
	assign cur     = ramp_spd_q;
	assign decel_path = counted && (cur > {2'b0, start_q});
	assign rem_m1  = goal_a - done_a - 1'b1;
	assign refuse  = !m_ok || (tgt_q == '0) || (active_q != NO_MOTOR);
	assign start_min = (tgt_q < {2'b0, start_q}) ? tgt_q : {2'b0, start_q};

	assign acc_eff = (acc_q == '0) ? CFG_W'(1) : acc_q;
	assign cnt_num = {1'b0, cur} - {3'b0, start_q} + {3'b0, acc_eff} - 1'b1;
	assign sum_avg = {1'b0, cur} + {3'b0, start_q};

	assign dvd = cmd.cnt_go ? DIV_W'(cnt_num) : DIV_W'(TIMER_BASE_HZ);
	assign dvs = cmd.cnt_go ? {2'b0, acc_eff} : cand_q;

	srt_div #(.DIV_W(DIV_W), .DVS_W(SPEED_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.cnt_go || cmd.per_go),
		.dividend (dvd),
		.divisor  (dvs),
		.quo      (quo),
		.done     (div_done)
	);

	assign q32 = 32'(quo);

	// Next ramp speed.
	assign decel    = decel_path && (prod_q > M2W'(rhs_q));
	assign diff     = cur - {2'b0, start_q};
	assign dec_next = (diff <= {2'b0, acc_q}) ? {2'b0, start_q} : cur - {2'b0, acc_q};
	assign up_sum   = {1'b0, cur} + {3'b0, acc_q};
	assign up_next  = (up_sum > {1'b0, ramp_tgt_q}) ? ramp_tgt_q : up_sum[SPEED_W-1:0];

	always_comb begin
		if (decel)
			next_spd = dec_next;
		else if ((counted || goal_a == '0) && cur < ramp_tgt_q)
			next_spd = up_next;
		else
			next_spd = cur;
	end

	assign done_inc = done_q[motor_q] + 1'b1;

	assign sts.mode          = mode_q;
	assign sts.start_refused = refuse;
	assign sts.tick_idle     = !(ramp_on_q && act_run);
	assign sts.decel_path    = decel_path;
	assign sts.same          = same_q;
	assign sts.div_done      = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= CFG_W'(200);
			acc_q   <= CFG_W'(50);
			tick_q  <= TICK_W'(10);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_SPEED: start_q <= cfg_data;
				CFG_ACCEL_STEP:  acc_q   <= cfg_data;
				CFG_TICK_MS:     tick_q  <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q  <= mode;
			motor_q <= motor;
			dir_q   <= direction;
			tgt_q   <= target_speed;
			steps_q <= step_count;
		end
		if (cmd.cand_start) begin
			cand_q <= start_min;
			same_q <= 1'b0;
		end else if (cmd.pick) begin
			cand_q <= next_spd;
			same_q <= (next_spd == cur);
		end
		if (cmd.mul1) begin
			mul1_q <= M1W'(sum_avg[CNT_W-1:1]) * M1W'(quo[CNT_W-1:0]);
			rhs_q  <= RW'(rem_m1) * RW'(1000);
		end
		if (cmd.mul2)
			prod_q <= M2W'(mul1_q) * M2W'(tick_q);
		if (cmd.per_cap) begin
			per_ok_q <= (cand_q != '0) && (q32 >= 32'(MIN_PERIOD_TICKS));
			per_q    <= (q32 > 32'(PERIOD_MAX)) ? PERIOD_MAX : q32[PERIOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				run_q[i]   <= 1'b0;
				mdir_q[i]  <= 1'b0;
				spd_q[i]   <= '0;
				per_m_q[i] <= '0;
				goal_q[i]  <= '0;
				done_q[i]  <= '0;
			end
			active_q   <= NO_MOTOR;
			ramp_on_q  <= 1'b0;
			ramp_tgt_q <= '0;
			ramp_spd_q <= '0;
			acc_out_q  <= 1'b0;
		end else if (cmd.commit) begin
			acc_out_q <= 1'b0;
			unique case (mode_q)
				MODE_START: begin
					// A refusal while a motor is active leaves everything as it was.
					if (active_q == NO_MOTOR) begin
						for (int i = 0; i < NUM_MOTORS; i++)
							run_q[i] <= 1'b0;
						ramp_on_q  <= 1'b0;
						ramp_tgt_q <= '0;
						ramp_spd_q <= '0;
						if (!refuse && per_ok_q) begin
							run_q[motor_q]   <= 1'b1;
							mdir_q[motor_q]  <= dir_q;
							spd_q[motor_q]   <= cand_q;
							per_m_q[motor_q] <= per_q;
							goal_q[motor_q]  <= steps_q;
							done_q[motor_q]  <= '0;
							active_q         <= {1'b0, motor_q};
							ramp_on_q        <= 1'b1;
							ramp_tgt_q       <= tgt_q;
							ramp_spd_q       <= cand_q;
							acc_out_q        <= 1'b1;
						end
					end
				end
				MODE_STOP: begin
					if (m_ok) begin
						run_q[motor_q] <= 1'b0;
						if (active_q == {1'b0, motor_q})
							active_q <= NO_MOTOR;
						ramp_on_q  <= 1'b0;
						ramp_tgt_q <= '0;
						ramp_spd_q <= '0;
					end
				end
				MODE_TICK: begin
					if (ramp_on_q && act_run && !same_q && per_ok_q) begin
						ramp_spd_q <= cand_q;
						spd_q[a]   <= cand_q;
						per_m_q[a] <= per_q;
					end
				end
				MODE_PULSE: begin
					if (m_ok && active_q == {1'b0, motor_q} && run_q[motor_q]) begin
						done_q[motor_q] <= done_inc;
						if (goal_q[motor_q] != '0 && done_inc >= goal_q[motor_q]) begin
							run_q[motor_q] <= 1'b0;
							active_q       <= NO_MOTOR;
							ramp_on_q      <= 1'b0;
							ramp_tgt_q     <= '0;
							ramp_spd_q     <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			accepted     <= acc_out_q;
			active_motor <= active_q;
			if (m_ok) begin
				running    <= run_q[motor_q];
				dir_out    <= mdir_q[motor_q];
				rate_pps   <= spd_q[motor_q];
				period_us  <= run_q[motor_q] ? per_m_q[motor_q] : '0;
				done_steps <= done_q[motor_q];
				goal_steps <= goal_q[motor_q];
			end else begin
				running    <= 1'b0;
				dir_out    <= 1'b0;
				rate_pps   <= '0;
				period_us  <= '0;
				done_steps <= '0;
				goal_steps <= '0;
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/srt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp controller
// Sequences one item through decode, estimate, divide, commit and output.
// ----------------------------------------------------------------------------
module srt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire srt_pkg::sts_t  sts,
	output srt_pkg::cmd_t       cmd
);
	import srt_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_CWAIT  = 4'd2;
	localparam logic [3:0] S_MUL1   = 4'd3;
	localparam logic [3:0] S_MUL2   = 4'd4;
	localparam logic [3:0] S_PICK   = 4'd5;
	localparam logic [3:0] S_PGO    = 4'd6;
	localparam logic [3:0] S_PWAIT  = 4'd7;
	localparam logic [3:0] S_COMMIT = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0] state_q, state_d;
	logic       ov_q;
	logic       load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign load      = (state_q == S_OUT) && (!ov_q || out_ready);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.mode)
					MODE_START: begin
						if (sts.start_refused) begin
							state_d = S_COMMIT;
						end else begin
							cmd.cand_start = 1'b1;
							state_d        = S_PGO;
						end
					end
					MODE_TICK: begin
						if (sts.tick_idle)
							state_d = S_COMMIT;
						else if (sts.decel_path) begin
							cmd.cnt_go = 1'b1;
							state_d    = S_CWAIT;
						end else
							state_d = S_PICK;
					end
					default: state_d = S_COMMIT;
				endcase
			end
			S_CWAIT: if (sts.div_done) state_d = S_MUL1;
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_PICK;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_PGO;
			end
			S_PGO: begin
				if (sts.same)
					state_d = S_COMMIT;
				else begin
					cmd.per_go = 1'b1;
					state_d    = S_PWAIT;
				end
			end
			S_PWAIT: begin
				if (sts.div_done) begin
					cmd.per_cap = 1'b1;
					state_d     = S_COMMIT;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (load) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

@@ rtl/stepper_trapezoid_ramp_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp unit
// Two-motor step-rate planner with one shared pulse timer period divider.
// ----------------------------------------------------------------------------
//  channel  | handshake            | contents
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//  in       | in_valid/in_ready    | mode, motor, direction, target_speed, step_count
//  out      | out_valid/out_ready  | accepted .. goal_steps, one item per input item
//
// One item at a time. Stop, pulse, refused start and idle tick items go from decode
// to commit and output; a start runs the period divide, a ramp tick picks the next
// speed and divides (not when it stays), a braking check first divides for the step
// count and multiplies, all on the one-bit-per-cycle divider (DIV_W is 20 by default).
// A finished item waits in the output register while the next one is taken.
// Reset is asynchronous and restores the configuration defaults and idle motors.
module stepper_trapezoid_ramp_unit
	#(
	parameter int NUM_MOTORS       = srt_pkg::NUM_MOTORS_DEF,
	parameter int TIMER_BASE_HZ    = srt_pkg::TIMER_BASE_HZ_DEF,
	parameter int MIN_PERIOD_TICKS = srt_pkg::MIN_PERIOD_TICKS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [srt_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [srt_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  mode,
	input  wire logic                        motor,
	input  wire logic                        direction,
	input  wire logic [srt_pkg::SPEED_W-1:0] target_speed,
	input  wire logic [srt_pkg::STEP_W-1:0]  step_count,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             accepted,
	output logic                             running,
	output logic [1:0]                       active_motor,
	output logic                             dir_out,
	output logic [srt_pkg::SPEED_W-1:0]      rate_pps,
	output logic [srt_pkg::PERIOD_W-1:0]     period_us,
	output logic [srt_pkg::STEP_W-1:0]       done_steps,
	output logic [srt_pkg::STEP_W-1:0]       goal_steps
);
	import srt_pkg::*;

	localparam int TB_W  = $clog2(TIMER_BASE_HZ + 1);
	localparam int DIV_W = (TB_W > CNT_W) ? TB_W : CNT_W;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	srt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	srt_dp #(
		.NUM_MOTORS       (NUM_MOTORS),
		.TIMER_BASE_HZ    (TIMER_BASE_HZ),
		.MIN_PERIOD_TICKS (MIN_PERIOD_TICKS),
		.DIV_W            (DIV_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.motor        (motor),
		.direction    (direction),
		.target_speed (target_speed),
		.step_count   (step_count),
		.cmd          (cmd),
		.sts          (sts),
		.accepted     (accepted),
		.running      (running),
		.active_motor (active_motor),
		.dir_out      (dir_out),
		.rate_pps     (rate_pps),
		.period_us    (period_us),
		.done_steps   (done_steps),
		.goal_steps   (goal_steps)
	);
endmodule
`default_nettype wire

@@ rtl/srt_chk.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp checker
// Port-level properties of the output items, bound to the top level.
// ----------------------------------------------------------------------------
module srt_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        accepted,
	input wire logic        running,
	input wire logic [1:0]  active_motor,
	input wire logic [19:0] period_us,
	input wire logic [17:0] rate_pps
);
	// A stalled item holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(period_us) && $stable(rate_pps))
		else $error("output item changed while stalled");

	// An accepted start leaves a running motor that is the active one.
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> running && active_motor != 2'd2)
		else $error("accepted start without active running motor");

	// A running motor always reports a usable period.
	a_per_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && running |-> period_us != 20'd0 && rate_pps != 18'd0)
		else $error("running motor with zero period or speed");

	// A stopped motor reports no period.
	a_per_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !running |-> period_us == 20'd0)
		else $error("idle motor with nonzero period");
endmodule

bind stepper_trapezoid_ramp_unit srt_chk u_srt_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.accepted     (accepted),
	.running      (running),
	.active_motor (active_motor),
	.period_us    (period_us),
	.rate_pps     (rate_pps)
);
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stepper trapezoid ramp unit testbench
// Drives start, stop, ramp tick and pulse items into the planner and checks
// every status item against a cycle-free model of both motors and the ramp,
// with random idling on both channels and several register settings.
// ----------------------------------------------------------------------------
module tb_top;
	import srt_pkg::*;

	typedef struct packed {
		logic                accepted;
		logic                running;
		logic [1:0]          active_motor;
		logic                dir_out;
		logic [SPEED_W-1:0]  rate_pps;
		logic [PERIOD_W-1:0] period_us;
		logic [STEP_W-1:0]   done_steps;
		logic [STEP_W-1:0]   goal_steps;
	} status_t;

	localparam int unsigned BASE_HZ = TIMER_BASE_HZ_DEF;
	localparam int unsigned MIN_PER = MIN_PERIOD_TICKS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] mode = MODE_STOP;
	logic motor = 1'b0;
	logic direction = 1'b0;
	logic [SPEED_W-1:0] target_speed = '0;
	logic [STEP_W-1:0] step_count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	wire status_t got;

	stepper_trapezoid_ramp_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .motor(motor), .direction(direction),
		.target_speed(target_speed), .step_count(step_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.accepted(got.accepted), .running(got.running),
		.active_motor(got.active_motor), .dir_out(got.dir_out),
		.rate_pps(got.rate_pps), .period_us(got.period_us),
		.done_steps(got.done_steps), .goal_steps(got.goal_steps)
	);

	always #6 clk = ~clk;

	// Planner state as the block should hold it.
	logic [15:0] cfg_start;
	logic [15:0] cfg_accel;
	logic [9:0] cfg_tick_ms;
	logic mot_run [2];
	logic mot_dir [2];
	logic [SPEED_W-1:0] mot_speed [2];
	logic [STEP_W-1:0] mot_goal [2];
	logic [STEP_W-1:0] mot_done [2];
	logic [1:0] act_idx;
	logic ramp_on;
	logic [SPEED_W-1:0] ramp_tgt;
	logic [SPEED_W-1:0] ramp_spd;

	status_t expected_status [$];
	int n_items = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_starts = 0;
	int n_cfg = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;

	function automatic logic [PERIOD_W-1:0] pulse_period(logic [SPEED_W-1:0] s);
		longint unsigned p;
		if (s == 0)
			return '0;
		p = BASE_HZ / s;
		if (p < MIN_PER)
			return '0;
		if (p > PERIOD_MAX)
			return PERIOD_MAX;
		return p[PERIOD_W-1:0];
	endfunction

	function automatic longint unsigned brake_distance(logic [SPEED_W-1:0] cur);
		longint unsigned dv;
		longint unsigned cnt;
		longint unsigned avg;
		dv = (cfg_accel != 0) ? cfg_accel : 1;
		if (cur <= cfg_start)
			return 0;
		cnt = (longint'(cur) - cfg_start + dv - 1) / dv;
		avg = (longint'(cur) + cfg_start) / 2;
		return (avg * cnt * cfg_tick_ms + 999) / 1000;
	endfunction

	task automatic reset_planner();
		cfg_start = 16'd200;
		cfg_accel = 16'd50;
		cfg_tick_ms = 10'd10;
		for (int i = 0; i < 2; i++) begin
			mot_run[i] = 0; mot_dir[i] = 0; mot_speed[i] = 0;
			mot_goal[i] = 0; mot_done[i] = 0;
		end
		act_idx = NO_MOTOR;
		ramp_on = 0; ramp_tgt = 0; ramp_spd = 0;
	endtask

	task automatic halt_motor(logic m);
		mot_run[m] = 0;
		if (act_idx == {1'b0, m})
			act_idx = NO_MOTOR;
		ramp_on = 0; ramp_tgt = 0; ramp_spd = 0;
	endtask

	task automatic plan_event(input logic [1:0] md, input logic m, input logic d,
			input logic [SPEED_W-1:0] tgt, input logic [STEP_W-1:0] st,
			output status_t r);
		logic acc;
		logic [SPEED_W-1:0] s;
		logic [SPEED_W-1:0] cur;
		longint unsigned nxt;
		logic [STEP_W-1:0] rem;
		logic a;
		acc = 0;
		case (md)
			MODE_START: begin
				if (tgt != 0 && act_idx == NO_MOTOR) begin
					mot_run[0] = 0; mot_run[1] = 0;
					ramp_on = 0; ramp_tgt = 0; ramp_spd = 0;
					s = (tgt < cfg_start) ? tgt : cfg_start;
					if (pulse_period(s) != 0) begin
						mot_run[m] = 1; mot_dir[m] = d; mot_speed[m] = s;
						mot_goal[m] = st; mot_done[m] = 0; act_idx = {1'b0, m};
						ramp_on = 1; ramp_tgt = tgt; ramp_spd = s;
						acc = 1;
					end
				end
			end
			MODE_STOP: halt_motor(m);
			MODE_TICK: begin
				if (ramp_on && act_idx != NO_MOTOR && mot_run[act_idx[0]]) begin
					a = act_idx[0];
					cur = ramp_spd;
					nxt = cur;
					if (mot_goal[a] != 0 && mot_done[a] < mot_goal[a]) begin
						rem = mot_goal[a] - mot_done[a];
						if (rem <= brake_distance(cur) && cur > cfg_start)
							nxt = (cur - cfg_start <= cfg_accel) ? cfg_start : cur - cfg_accel;
						else if (cur < ramp_tgt) begin
							nxt = longint'(cur) + cfg_accel;
							if (nxt > ramp_tgt)
								nxt = ramp_tgt;
						end
					end else if (mot_goal[a] == 0 && cur < ramp_tgt) begin
						nxt = longint'(cur) + cfg_accel;
						if (nxt > ramp_tgt)
							nxt = ramp_tgt;
					end
					if (nxt != cur && pulse_period(nxt[SPEED_W-1:0]) != 0) begin
						ramp_spd = nxt[SPEED_W-1:0];
						mot_speed[a] = nxt[SPEED_W-1:0];
					end
				end
			end
			default: begin
				if (act_idx == {1'b0, m} && mot_run[m]) begin
					mot_done[m] = mot_done[m] + 1'b1;
					if (mot_goal[m] != 0 && mot_done[m] >= mot_goal[m])
						halt_motor(m);
				end
			end
		endcase
		r.accepted = acc;
		r.running = mot_run[m];
		r.active_motor = act_idx;
		r.dir_out = mot_dir[m];
		r.rate_pps = mot_speed[m];
		r.period_us = mot_run[m] ? pulse_period(mot_speed[m]) : '0;
		r.done_steps = mot_done[m];
		r.goal_steps = mot_goal[m];
		if (acc)
			n_starts++;
	endtask

	// Sends one item; the caller is always just past a rising edge.
	task automatic send_event(logic [1:0] md, logic m, logic d,
			logic [SPEED_W-1:0] tgt, logic [STEP_W-1:0] st);
		int gap;
		status_t r;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md; motor <= m; direction <= d;
		target_speed <= tgt; step_count <= st;
		do @(posedge clk); while (!in_ready);
		plan_event(md, m, d, tgt, st, r);
		expected_status.push_back(r);
		n_items++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_START_SPEED: cfg_start = val;
			CFG_ACCEL_STEP: cfg_accel = val;
			CFG_TICK_MS: cfg_tick_ms = val[9:0];
			default: ;
		endcase
		n_cfg++;
		@(posedge clk);
	endtask

	task automatic set_profile(logic [15:0] sp, logic [15:0] ac, logic [9:0] tk);
		wait_drained();
		write_reg(CFG_START_SPEED, sp);
		write_reg(CFG_ACCEL_STEP, ac);
		write_reg(CFG_TICK_MS, {6'd0, tk});
	endtask

	// A well-formed move with random content, and the odd stray item.
	task automatic random_move();
		logic m;
		logic [SPEED_W-1:0] tgt;
		logic [STEP_W-1:0] st;
		int sel;
		int k;
		m = 1'($urandom_range(0, 1));
		sel = $urandom_range(0, 9);
		tgt = (sel < 6) ? SPEED_W'($urandom_range(1, 3000)) :
			SPEED_W'($urandom_range(0, 262143));
		sel = $urandom_range(0, 9);
		st = (sel < 7) ? STEP_W'($urandom_range(1, 60)) :
			(sel < 9) ? STEP_W'(0) : STEP_W'($urandom_range(0, 131071));
		send_event(MODE_START, m, 1'($urandom_range(0, 1)), tgt, st);
		k = 0;
		while (mot_run[m] && k < 100) begin
			sel = $urandom_range(0, 99);
			if (sel < 45)
				send_event(MODE_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					SPEED_W'($urandom_range(0, 262143)),
					STEP_W'($urandom_range(0, 131071)));
			else if (sel < 92)
				send_event(MODE_PULSE, m, 1'($urandom_range(0, 1)), 0, 0);
			else if (sel < 95)
				send_event(MODE_PULSE, ~m, 0, 0, 0);
			else if (sel < 97)
				send_event(MODE_START, 1'($urandom_range(0, 1)), 1,
					SPEED_W'($urandom_range(1, 9999)), 5);
			else
				send_event(MODE_STOP, 1'($urandom_range(0, 1)), 0, 0, 0);
			k++;
		end
		if (mot_run[m])
			send_event(MODE_STOP, m, 0, 0, 0);
	endtask

	task automatic test_directed();
		send_event(MODE_TICK, 0, 0, 0, 0);
		send_event(MODE_PULSE, 1, 0, 0, 0);
		send_event(MODE_START, 0, 1, 0, 10);
		send_event(MODE_START, 1, 1, 18'h3FFFF, 17'h1FFFF);
		send_event(MODE_START, 0, 0, 1000, 3);
		send_event(MODE_PULSE, 0, 0, 0, 0);
		send_event(MODE_TICK, 0, 0, 0, 0);
		send_event(MODE_STOP, 0, 0, 0, 0);
		send_event(MODE_TICK, 0, 0, 0, 0);
		send_event(MODE_STOP, 1, 0, 0, 0);
		send_event(MODE_START, 0, 0, 100, 3);
		send_event(MODE_PULSE, 1, 0, 0, 0);
		send_event(MODE_PULSE, 0, 0, 0, 0);
		send_event(MODE_PULSE, 0, 0, 0, 0);
		send_event(MODE_PULSE, 0, 0, 0, 0);
		send_event(MODE_TICK, 0, 0, 0, 0);
		send_event(MODE_START, 1, 0, 400, 0);
		for (int i = 0; i < 6; i++)
			send_event(MODE_TICK, 0, 0, 0, 0);
		send_event(MODE_PULSE, 1, 0, 0, 0);
		send_event(MODE_STOP, 1, 0, 0, 0);
	endtask

	task automatic test_profiles();
		set_profile(16'd1, 16'd1, 10'd1);
		repeat (6) random_move();
		set_profile(16'hFFFF, 16'hFFFF, 10'd1000);
		repeat (6) random_move();
		set_profile(16'd1, 16'hFFFF, 10'd1000);
		repeat (6) random_move();
		set_profile(16'd3000, 16'd7, 10'd250);
		repeat (6) random_move();
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_req = 1'b1;
		send_event(MODE_START, 0, 1, 5000, 0);
		repeat (12) send_event(MODE_TICK, 0, 0, 0, 0);
		send_event(MODE_STOP, 0, 0, 0, 0);
		wait_drained();
	endtask

	task automatic test_random();
		int phase;
		phase = 0;
		while (n_items < 1300) begin
			if (n_items / 400 != phase) begin
				phase = n_items / 400;
				set_profile(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
					10'($urandom_range(1, 1000)));
				no_idle = (phase == 2);
			end
			random_move();
		end
		no_idle = 1'b0;
	endtask

	// Status side: a random stall before each item, or a long hold on request.
	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				stall = 300;
				hold_req = 1'b0;
			end else
				stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic check_field(string name, longint unsigned e, longint unsigned a);
		if (e != a) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
		end
	endtask

	always @(posedge clk) begin
		status_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_status.size() == 0) begin
				n_errors++;
				$display("%0t: status item with none expected, got %h", $time, got);
			end else begin
				e = expected_status.pop_front();
				check_field("accepted", e.accepted, got.accepted);
				check_field("running", e.running, got.running);
				check_field("active_motor", e.active_motor, got.active_motor);
				check_field("dir_out", e.dir_out, got.dir_out);
				check_field("rate_pps", e.rate_pps, got.rate_pps);
				check_field("period_us", e.period_us, got.period_us);
				check_field("done_steps", e.done_steps, got.done_steps);
				check_field("goal_steps", e.goal_steps, got.goal_steps);
				n_checked++;
			end
		end
	end

	initial begin
		#20ms;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		reset_planner();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_profiles();
		test_backpressure();
		test_random();
		set_profile(16'd200, 16'd50, 10'd10);
		repeat (3) random_move();
		wait_drained();
		repeat (100) @(posedge clk);
		if (expected_status.size() != 0) begin
			n_errors++;
			$display("%0t: %0d status items never arrived", $time, expected_status.size());
		end
		$display("Sent %0d items (%0d accepted starts), checked %0d status items,",
			n_items, n_starts, n_checked);
		$display("over %0d register writes and %0d mismatches.", n_cfg, n_errors);
		if (n_errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/srt_pkg.sv
rtl/srt_div.sv
rtl/srt_dp.sv
rtl/srt_ctrl.sv
rtl/stepper_trapezoid_ramp_unit.sv
rtl/srt_chk.sv
tb/tb_top.sv
